// File: sv/three_voice_wavetable_mixer_assert.svh
// Assertion macros for the three-voice wavetable mixer.
// Included by the top-level module; expects clk_i and rst_ni in scope.
`ifndef THREE_VOICE_WAVETABLE_MIXER_ASSERT_SVH
`define THREE_VOICE_WAVETABLE_MIXER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define TVWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define TVWM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: sv/tvwm_pkg.sv
// Shared constants, types and the waveform function of the wavetable mixer.
// No dependencies; imported by the top-level module.
package tvwm_pkg;

  localparam int VOICES        = 3;
  localparam int TABLE_ENTRIES = 256;

  localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W   = $clog2(VOICES + 1);
  localparam int ACC_W   = 17 + VOICE_W;

  localparam int RATE_HZ     = 44100;
  // floor(2^32 / RATE_HZ); estimate of freq*65536/RATE_HZ is low by at most one.
  localparam int RECIP_RATE  = 97391;
  localparam int LEVEL_FULL  = 255;
  // floor(2^23 / LEVEL_FULL); estimate of p/255 is low by at most one.
  localparam int RECIP_LEVEL = 32896;
  localparam int STEP_SLOPE  = 512;
  localparam int FULL_POS    = 32767;
  localparam int FULL_NEG    = -32768;

  typedef enum logic [1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_TICK     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    WAVE_TRI    = 2'd0,
    WAVE_PULSE  = 2'd1,
    WAVE_RAMP   = 2'd2,
    WAVE_SILENT = 2'd3
  } wave_e;

  typedef struct packed {
    logic [15:0] phase;
    logic [16:0] incr;
    logic [1:0]  wave;
    logic [7:0]  level;
    logic        on;
  } voice_rec_t;

  function automatic logic signed [15:0] wave_value(logic [1:0] wave, logic [7:0] idx);
    int i;
    int v;
    i = int'(idx);
    case (wave_e'(wave))
      WAVE_TRI: begin
        if (i < 64) v = i * STEP_SLOPE;
        else if (i < 128) v = FULL_POS - (i - 64) * STEP_SLOPE;
        else if (i < 192) v = -((i - 128) * STEP_SLOPE);
        else v = -FULL_POS + (i - 192) * STEP_SLOPE;
      end
      WAVE_PULSE: v = (i < TABLE_ENTRIES / 2) ? FULL_POS : -FULL_POS;
      WAVE_RAMP:  v = i * 256 + FULL_NEG;
      default:    v = 0;
    endcase
    return 16'(v);
  endfunction

endpackage

// File: sv/tvwm_if.sv
// Request and sample channel interfaces of the wavetable mixer.
// Plain valid/ready channels; no package dependency.
interface tvwm_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  voice;
  logic [15:0] frequency;
  logic [1:0]  waveform;
  logic [7:0]  volume;

  modport source (output valid, command, voice, frequency, waveform, volume, input ready);
  modport sink   (input valid, command, voice, frequency, waveform, volume, output ready);
endinterface

interface tvwm_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

// File: sv/three_voice_wavetable_mixer.sv
// Channel   | Dir | Payload                                        | Notes
// cmd_i     | in  | command, voice, frequency, waveform, volume   | one request at a time
// smp_o     | out | sample (signed 16)                             | one per tick request
// Note on passes through S_ON_MUL and S_ON_FIX, note off through S_OFF_RD and S_OFF_WR,
// before ready returns. During a tick the voice memory's single read port visits one
// voice per cycle, followed by a three-stage scale pipeline.
// Reset clears the per-voice valid bits at once; no clearing pass is needed.
// A finished sample waits in the output register; a tick only stalls at its end
// when the previous sample has not yet been taken.
// Depends on tvwm_pkg, tvwm_if.sv and three_voice_wavetable_mixer_assert.svh.
`include "three_voice_wavetable_mixer_assert.svh"

module three_voice_wavetable_mixer (
  input logic          clk_i,
  input logic          rst_ni,
  tvwm_cmd_if.sink     cmd_i,
  tvwm_smp_if.source   smp_o
);
  import tvwm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ON_MUL,
    S_ON_FIX,
    S_OFF_RD,
    S_OFF_WR,
    S_TICK,
    S_MIX
  } state_e;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(FULL_POS);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(FULL_NEG);

  state_e state_q, state_d;
  logic [CNT_W-1:0] iss_q, iss_d;
  logic p1_q, p1_d, p2_q, p3_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic out_vld_q, out_vld_d;
  logic signed [15:0] sample_q, sample_d;
  logic [VOICES-1:0] vld_q;
  logic rd_vld_q;

  // Voice memory with registered read data.
  voice_rec_t mem [VOICES];
  voice_rec_t rd_data_q;
  logic mem_we, mem_re;
  logic [VOICE_W-1:0] mem_waddr, mem_raddr;
  voice_rec_t mem_wdata;

  // Request fields and pipeline payload.
  logic [VOICE_W-1:0] req_voice_q;
  logic [15:0] req_freq_q;
  logic [1:0]  req_wave_q;
  logic [7:0]  req_vol_q;
  logic [16:0] inc_est_q;
  logic [VOICE_W-1:0] p1_idx_q;
  logic [22:0] p2_prod_q, p3_prod_q;
  logic p2_neg_q, p3_neg_q;
  logic [15:0] p3_qe_q;

  logic accept;
  logic voice_ok;
  voice_rec_t rec;
  logic signed [15:0] wv_a;
  logic [15:0] mag_a;
  logic [22:0] prod_a;
  logic [32:0] inc_mul;
  logic [31:0] inc_rem;
  logic [16:0] inc_fix;
  logic [38:0] lvl_mul;
  logic [23:0] qe255_c, rem_c;
  logic [15:0] q_c;
  logic signed [ACC_W-1:0] mag_c, contrib_c;
  logic signed [15:0] sat;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign voice_ok = (32'(cmd_i.voice) < VOICES);
  assign cmd_i.ready  = (state_q == S_IDLE);
  assign smp_o.valid  = out_vld_q;
  assign smp_o.sample = sample_q;

  // Entries never written read as the reset record.
  assign rec = rd_vld_q ? rd_data_q : '0;

  // Stage A: waveform lookup and level multiply.
  always_comb begin
    wv_a   = rec.on ? wave_value(rec.wave, rec.phase[15:8]) : 16'sd0;
    mag_a  = wv_a[15] ? 16'(-wv_a) : 16'(wv_a);
    prod_a = 23'(24'(mag_a) * 24'(rec.level));
  end

  // Stage B estimate of prod/255 and stage C correction.
  always_comb begin
    lvl_mul   = 39'(p2_prod_q) * 39'(RECIP_LEVEL);
    qe255_c   = {p3_qe_q, 8'd0} - 24'(p3_qe_q);
    rem_c     = 24'(p3_prod_q) - qe255_c;
    q_c       = p3_qe_q + ((rem_c >= 24'(LEVEL_FULL)) ? 16'd1 : 16'd0);
    mag_c     = ACC_W'(q_c);
    contrib_c = p3_neg_q ? -mag_c : mag_c;
  end

  // Increment = floor(freq * 65536 / RATE_HZ) by reciprocal with one correction.
  always_comb begin
    inc_mul = 33'(req_freq_q) * 33'(RECIP_RATE);
    inc_rem = {req_freq_q, 16'd0} - 32'(inc_est_q) * 32'(RATE_HZ);
    inc_fix = inc_est_q + ((inc_rem >= 32'(RATE_HZ)) ? 17'd1 : 17'd0);
  end

  always_comb begin
    if (acc_q > ACC_MAX) sat = 16'(FULL_POS);
    else if (acc_q < ACC_MIN) sat = 16'(FULL_NEG);
    else sat = acc_q[15:0];
  end

  // Memory port selection.
  always_comb begin
    mem_re    = ((state_q == S_TICK) && (iss_q < CNT_W'(VOICES))) || (state_q == S_OFF_RD);
    mem_raddr = (state_q == S_TICK) ? iss_q[VOICE_W-1:0] : req_voice_q;
    mem_we    = 1'b0;
    mem_waddr = req_voice_q;
    mem_wdata = rec;
    case (state_q)
      S_TICK: begin
        if (p1_q && rec.on) begin
          mem_we          = 1'b1;
          mem_waddr       = p1_idx_q;
          mem_wdata.phase = rec.phase + rec.incr[15:0];
        end
      end
      S_ON_FIX: begin
        mem_we          = 1'b1;
        mem_wdata.phase = '0;
        mem_wdata.incr  = inc_fix;
        mem_wdata.wave  = req_wave_q;
        mem_wdata.level = req_vol_q;
        mem_wdata.on    = 1'b1;
      end
      S_OFF_WR: begin
        mem_we          = 1'b1;
        mem_wdata.level = '0;
        mem_wdata.on    = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    acc_d     = acc_q;
    p1_d      = 1'b0;
    out_vld_d = out_vld_q && !smp_o.ready;
    sample_d  = sample_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i.command))
            CMD_NOTE_ON:  if (voice_ok) state_d = S_ON_MUL;
            CMD_NOTE_OFF: if (voice_ok) state_d = S_OFF_RD;
            CMD_TICK: begin
              state_d = S_TICK;
              iss_d   = '0;
              acc_d   = '0;
            end
            default: ;
          endcase
        end
      end
      S_ON_MUL: state_d = S_ON_FIX;
      S_ON_FIX: state_d = S_IDLE;
      S_OFF_RD: state_d = S_OFF_WR;
      S_OFF_WR: state_d = S_IDLE;
      S_TICK: begin
        if (iss_q < CNT_W'(VOICES)) begin
          p1_d  = 1'b1;
          iss_d = iss_q + 1'b1;
        end
        if (p3_q) acc_d = acc_q + contrib_c;
        if ((iss_q == CNT_W'(VOICES)) && !p1_q && !p2_q && !p3_q) state_d = S_MIX;
      end
      S_MIX: begin
        if (!out_vld_q || smp_o.ready) begin
          out_vld_d = 1'b1;
          sample_d  = sat;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      iss_q     <= '0;
      acc_q     <= '0;
      p1_q      <= 1'b0;
      p2_q      <= 1'b0;
      p3_q      <= 1'b0;
      out_vld_q <= 1'b0;
      sample_q  <= '0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      acc_q     <= acc_d;
      p1_q      <= p1_d;
      p2_q      <= p1_q;
      p3_q      <= p2_q;
      out_vld_q <= out_vld_d;
      sample_q  <= sample_d;
      if (mem_we) vld_q[mem_waddr] <= 1'b1;
      if (mem_re) rd_vld_q <= vld_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_voice_q <= VOICE_W'(cmd_i.voice);
      req_freq_q  <= cmd_i.frequency;
      req_wave_q  <= cmd_i.waveform;
      req_vol_q   <= cmd_i.volume;
    end
    if (state_q == S_ON_MUL) inc_est_q <= inc_mul[32:16];
    if (mem_re) p1_idx_q <= mem_raddr;
    p2_prod_q <= prod_a;
    p2_neg_q  <= wv_a[15];
    p3_prod_q <= p2_prod_q;
    p3_neg_q  <= p2_neg_q;
    p3_qe_q   <= lvl_mul[38:23];
  end

  `TVWM_ASSERT(a_pipe_in_tick, (p1_q || p2_q || p3_q) |-> (state_q == S_TICK), "scale pipeline busy outside a tick")
  `TVWM_ASSERT_NEVER(a_iss_range, iss_q > CNT_W'(VOICES), "voice issue counter overran")
  `TVWM_ASSERT(a_mix_holds, (state_q == S_MIX && out_vld_q && !smp_o.ready) |=> (state_q == S_MIX), "mixed sample dropped while output is stalled")
  `TVWM_ASSERT(a_acc_clear, (state_q == S_TICK && $past(state_q) == S_IDLE) |-> (acc_q == '0), "tick started with a stale accumulator")

endmodule

// File: sim/testbench.sv
// Self-checking bench for the three-voice wavetable mixer: request and sample channels
// with random gaps, checked against a behavioral model of the oscillators and the mix.
// Depends on tvwm_pkg, tvwm_if.sv and three_voice_wavetable_mixer.sv.
`timescale 1ns / 100ps

module testbench;
  import tvwm_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] VOICE_SPARE = 2'd3;
  localparam int         MIX_RATE    = 44100;
  localparam int         LEVEL_MAX   = 255;
  localparam int         PEAK        = 32767;
  localparam int         TROUGH      = -32768;
  localparam int         RANDOM_REQS = 1650;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         IDLE_PCT    = 35;

  typedef struct {
    logic [1:0]  command;
    logic [1:0]  voice;
    logic [15:0] frequency;
    logic [1:0]  waveform;
    logic [7:0]  volume;
    bit          drain;
  } req_t;

  logic clk;
  logic rst_n;

  tvwm_cmd_if cmd_bus ();
  tvwm_smp_if smp_bus ();

  three_voice_wavetable_mixer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_bus.sink),
    .smp_o  (smp_bus.source)
  );

  req_t               pending[$];
  logic signed [15:0] sample_due[$];

  // Oscillator state as the bench sees it.
  logic [15:0] osc_phase [VOICES];
  logic [16:0] osc_step  [VOICES];
  logic [1:0]  osc_wave  [VOICES];
  logic [7:0]  osc_level [VOICES];
  bit          osc_on    [VOICES];

  int  errors;
  int  accepted_reqs;
  int  tick_count;
  int  note_on_count;
  int  note_off_count;
  int  ignored_count;
  int  clip_count;
  int  cycle_count;
  bit  cmd_taken;
  wire calm = (accepted_reqs >= 700) && (accepted_reqs < 1000);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int wave_point(logic [1:0] w, logic [7:0] idx);
    int seg;
    seg = int'(idx[5:0]) * 512;
    case (w)
      WAVE_TRI: begin
        case (idx[7:6])
          2'd0:    return seg;
          2'd1:    return PEAK - seg;
          2'd2:    return -seg;
          default: return -PEAK + seg;
        endcase
      end
      WAVE_PULSE: return idx[7] ? -PEAK : PEAK;
      WAVE_RAMP:  return (int'(idx) - 128) * 256;
      default:    return 0;
    endcase
  endfunction

  function automatic int level_scaled(int v, logic [7:0] level);
    int mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * int'(level)) / LEVEL_MAX;
    return (v < 0) ? -mag : mag;
  endfunction

  task automatic apply_request(input req_t r, output bit emits,
                               output logic signed [15:0] mixed);
    longint unsigned scaled_freq;
    int acc;
    emits = 1'b0;
    mixed = '0;
    case (r.command)
      CMD_NOTE_ON: begin
        if (r.voice < VOICES) begin
          scaled_freq = longint'(r.frequency) << 16;
          osc_step[r.voice]  = 17'(scaled_freq / MIX_RATE);
          osc_wave[r.voice]  = r.waveform;
          osc_level[r.voice] = r.volume;
          osc_phase[r.voice] = '0;
          osc_on[r.voice]    = 1'b1;
          note_on_count++;
        end else begin
          ignored_count++;
        end
      end
      CMD_NOTE_OFF: begin
        if (r.voice < VOICES) begin
          osc_on[r.voice]    = 1'b0;
          osc_level[r.voice] = '0;
          note_off_count++;
        end else begin
          ignored_count++;
        end
      end
      CMD_TICK: begin
        acc = 0;
        for (int k = 0; k < VOICES; k++) begin
          if (osc_on[k]) begin
            acc += level_scaled(wave_point(osc_wave[k], osc_phase[k][15:8]), osc_level[k]);
            osc_phase[k] = osc_phase[k] + osc_step[k][15:0];
          end
        end
        if (acc > PEAK || acc < TROUGH) clip_count++;
        if (acc > PEAK) acc = PEAK;
        if (acc < TROUGH) acc = TROUGH;
        mixed = 16'(acc);
        emits = 1'b1;
        tick_count++;
      end
      default: ignored_count++;
    endcase
  endtask

  task automatic push_req(logic [1:0] command, logic [1:0] voice, logic [15:0] frequency,
                          logic [1:0] waveform, logic [7:0] volume, bit drain = 1'b0);
    req_t r;
    r.command   = command;
    r.voice     = voice;
    r.frequency = frequency;
    r.waveform  = waveform;
    r.volume    = volume;
    r.drain     = drain;
    pending.push_back(r);
  endtask

  task automatic push_tick(bit drain = 1'b0);
    push_req(CMD_TICK, 2'($urandom_range(3)), 16'($urandom), 2'($urandom_range(3)),
             8'($urandom), drain);
  endtask

  // Requests are applied to the model as the handshake completes; samples are
  // checked against the oldest outstanding tick.
  always @(posedge clk or negedge rst_n) begin : sample_proc
    req_t               r;
    bit                 emits;
    logic signed [15:0] mixed;
    logic signed [15:0] want;
    if (!rst_n) begin
      cmd_taken     <= 1'b0;
      accepted_reqs <= 0;
    end else begin
      cmd_taken <= cmd_bus.valid && cmd_bus.ready;
      if (smp_bus.valid && smp_bus.ready) begin
        if (sample_due.size() == 0) begin
          $error("sample: unexpected result %0d with no tick outstanding", smp_bus.sample);
          errors++;
        end else begin
          want = sample_due.pop_front();
          if (smp_bus.sample !== want) begin
            $error("sample mismatch: expected %0d, got %0d", want, smp_bus.sample);
            errors++;
          end
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        r.command   = cmd_bus.command;
        r.voice     = cmd_bus.voice;
        r.frequency = cmd_bus.frequency;
        r.waveform  = cmd_bus.waveform;
        r.volume    = cmd_bus.volume;
        r.drain     = 1'b0;
        apply_request(r, emits, mixed);
        if (emits) sample_due.push_back(mixed);
        accepted_reqs <= accepted_reqs + 1;
      end
    end
  end

  always @(negedge clk) begin : drive_proc
    req_t nxt;
    if (rst_n) begin
      if (!cmd_bus.valid || cmd_taken) begin
        // A drain request holds off until every outstanding sample has been taken.
        if (pending.size() != 0 && !(pending[0].drain && sample_due.size() != 0) &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending.pop_front();
          cmd_bus.command   <= nxt.command;
          cmd_bus.voice     <= nxt.voice;
          cmd_bus.frequency <= nxt.frequency;
          cmd_bus.waveform  <= nxt.waveform;
          cmd_bus.volume    <= nxt.volume;
          cmd_bus.valid     <= 1'b1;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
      smp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
             sample_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int counted;
    int roll;
    int burst;
    logic [15:0] freq;
    logic [7:0]  vol;
    errors         = 0;
    tick_count     = 0;
    note_on_count  = 0;
    note_off_count = 0;
    ignored_count  = 0;
    clip_count     = 0;
    cycle_count    = 0;
    for (int k = 0; k < VOICES; k++) begin
      osc_phase[k] = '0;
      osc_step[k]  = '0;
      osc_wave[k]  = WAVE_TRI;
      osc_level[k] = '0;
      osc_on[k]    = 1'b0;
    end
    rst_n             = 1'b0;
    cmd_bus.valid     = 1'b0;
    cmd_bus.command   = CMD_NOTE_ON;
    cmd_bus.voice     = '0;
    cmd_bus.frequency = '0;
    cmd_bus.waveform  = WAVE_TRI;
    cmd_bus.volume    = '0;
    smp_bus.ready     = 1'b0;

    // Directed part. A tick with every voice idle gives silence.
    push_tick();
    // Three full squares at top frequency: positive clip twice, then negative clip
    // once the phase reaches the second half of the table.
    for (int k = 0; k < VOICES; k++) push_req(CMD_NOTE_ON, 2'(k), 16'hFFFF, WAVE_PULSE, 8'hFF);
    repeat (3) push_tick();
    // Out-of-range voice and the spare command code change nothing.
    push_req(CMD_NOTE_ON, VOICE_SPARE, 16'd1234, WAVE_RAMP, 8'h00);
    push_req(CMD_NOTE_OFF, VOICE_SPARE, 16'hFFFF, WAVE_SILENT, 8'hFF);
    push_req(CMD_UNUSED, 2'd1, 16'hA5A5, WAVE_RAMP, 8'h5A);
    // Frozen triangle, half-level saw and a silent voice that still advances.
    push_req(CMD_NOTE_ON, 2'd0, 16'd0, WAVE_TRI, 8'hFF);
    push_req(CMD_NOTE_ON, 2'd1, 16'd1000, WAVE_RAMP, 8'h80);
    push_req(CMD_NOTE_ON, 2'd2, 16'd440, WAVE_SILENT, 8'hFF);
    repeat (3) push_tick();
    push_req(CMD_NOTE_OFF, 2'd1, 16'd0, WAVE_TRI, 8'h00);
    push_req(CMD_NOTE_ON, 2'd2, 16'd20000, WAVE_TRI, 8'h00);
    repeat (2) push_tick();
    push_req(CMD_NOTE_OFF, 2'd0, 16'd0, WAVE_TRI, 8'h00);
    push_req(CMD_NOTE_OFF, 2'd2, 16'd0, WAVE_TRI, 8'h00);
    push_tick(1'b1);

    // Random part: mostly notes and runs of ticks, with a little noise mixed in.
    counted = 0;
    while (counted < RANDOM_REQS) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst; b++) begin
          push_tick((counted % 250) == 249);
          counted++;
        end
      end else if (roll < 75) begin
        roll = $urandom_range(99);
        if (roll < 60) freq = 16'($urandom_range(20, 4000));
        else if (roll < 90) freq = 16'($urandom);
        else freq = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        roll = $urandom_range(99);
        if (roll < 70) vol = 8'($urandom);
        else vol = $urandom_range(1) ? 8'hFF : 8'h00;
        push_req(CMD_NOTE_ON, 2'($urandom_range(VOICES - 1)), freq, 2'($urandom_range(3)), vol);
        counted++;
      end else if (roll < 87) begin
        push_req(CMD_NOTE_OFF, 2'($urandom_range(VOICES - 1)), 16'($urandom),
                 2'($urandom_range(3)), 8'($urandom));
        counted++;
      end else if (roll < 93) begin
        push_req(CMD_UNUSED, 2'($urandom_range(3)), 16'($urandom), 2'($urandom_range(3)),
                 8'($urandom));
      end else begin
        push_req($urandom_range(1) ? CMD_NOTE_ON : CMD_NOTE_OFF, VOICE_SPARE, 16'($urandom),
                 2'($urandom_range(3)), 8'($urandom));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pending.size() == 0 && !cmd_bus.valid);
    wait (sample_due.size() == 0);
    repeat (20) @(posedge clk);

    $display("covered %0d ticks (%0d clipped), %0d note-ons, %0d note-offs, %0d ignored",
             tick_count, clip_count, note_on_count, note_off_count, ignored_count);
    $display("%0d requests accepted in %0d cycles, %0d mismatches", accepted_reqs,
             cycle_count, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: three_voice_wavetable_mixer.f
+incdir+sv
sv/tvwm_pkg.sv
sv/tvwm_if.sv
sv/three_voice_wavetable_mixer.sv
sim/testbench.sv
